FILE: hw/rtl/rtcm3fp_pkg.sv
// Shared constants and the CRC-24Q byte update for the RTCM3 frame parser.
package rtcm3fp_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgPreamble   = 2'd0;
  localparam logic [1:0] CfgMaxPayload = 2'd1;

  // Register reset values
  localparam logic [7:0] PreambleReset   = 8'hD3;
  localparam logic [9:0] MaxPayloadReset = 10'h3FF;

  // CRC-24Q generator, including the x^24 term
  localparam logic [24:0] Crc24qPoly = 25'h1864CFB;

  // Number of CRC bytes that close a frame
  localparam logic [10:0] CrcBytes = 11'd3;

  // One byte of CRC-24Q, MSB first, eight shift/xor steps
  function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
    logic [24:0] c;
    c = {1'b0, crc ^ {b, 16'h0000}};
    for (int k = 0; k < 8; k++) begin
      c = {c[23:0], 1'b0};
      if (c[24]) begin
        c = c ^ Crc24qPoly;
      end
    end
    return c[23:0];
  endfunction

endpackage

FILE: hw/rtl/rtcm3_frame_parser_unit.sv
// RTCM3 byte-serial frame parser with on-the-fly CRC-24Q check.
//
// Usage:
//   Input channel: one received byte per item on data_byte_i, handed over
//   when in_valid_i is high and in_stall_o is low.
//   Output channel: exactly one result item per input byte, taken when
//   out_valid_o is high and out_stall_i is low. frame_done_o marks the last
//   CRC byte of a frame, with crc_ok_o, message_id_o and payload_length_o;
//   length_error_o marks a header whose length is zero or above max_payload.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 = preamble value, 1 = max payload); other indexes are ignored.
// Timing:
//   A byte goes into an input register, then the framing state and CRC are
//   updated and the result lands in the output register. One byte per cycle
//   is sustained while the output is not stalled; the byte-wise CRC update
//   plus the length compare set the path.
//   While the output is stalled one more byte is buffered, then in_stall_o
//   rises.
// Reset: the parser hunts for the preamble, both channels are empty and the
//   registers return to 0xD3 and 1023.
module rtcm3_frame_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        frame_done_o,
  output logic        crc_ok_o,
  output logic [11:0] message_id_o,
  output logic [9:0]  payload_length_o,
  output logic        length_error_o
);

  // Phase codes
  localparam logic [1:0] PhHunt    = 2'd0;
  localparam logic [1:0] PhLength  = 2'd1;
  localparam logic [1:0] PhPayload = 2'd2;
  localparam logic [1:0] PhCrc     = 2'd3;

  // Configuration registers
  logic [7:0] preamble_q;
  logic [9:0] max_payload_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q    <= rtcm3fp_pkg::PreambleReset;
      max_payload_q <= rtcm3fp_pkg::MaxPayloadReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rtcm3fp_pkg::CfgPreamble:   preamble_q    <= cfg_data_i[7:0];
        rtcm3fp_pkg::CfgMaxPayload: max_payload_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: input register feeds the result register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  logic       advance;
  logic       in_accept;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= data_byte_i;
    end
  end

  // Framing state
  logic [1:0]  phase_q, phase_d;
  logic [9:0]  pos_q, pos_d;
  logic [1:0]  len_hi_q, len_hi_d;
  logic [9:0]  frame_len_q, frame_len_d;
  logic [23:0] crc_q, crc_d;
  logic [23:0] crc_rx_q, crc_rx_d;
  logic [11:0] id_q, id_d;

  // Result of the current byte
  logic        done_d, ok_d, lerr_d;
  logic [11:0] mid_d;
  logic [9:0]  plen_d;

  logic [23:0] crc_upd;
  logic [10:0] pos_inc;
  logic [9:0]  hdr_len;

  assign crc_upd = rtcm3fp_pkg::crc24q_byte(crc_q, byte_q);
  assign pos_inc = {1'b0, pos_q} + 11'd1;
  assign hdr_len = {len_hi_q, byte_q};

  // Next state and result for one byte
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    len_hi_d    = len_hi_q;
    frame_len_d = frame_len_q;
    crc_d       = crc_q;
    crc_rx_d    = crc_rx_q;
    id_d        = id_q;
    done_d      = 1'b0;
    ok_d        = 1'b0;
    lerr_d      = 1'b0;
    mid_d       = '0;
    plen_d      = '0;
    unique case (phase_q)
      PhHunt: begin
        if (byte_q == preamble_q) begin
          crc_d   = rtcm3fp_pkg::crc24q_byte(24'h000000, byte_q);
          pos_d   = '0;
          phase_d = PhLength;
        end
      end
      PhLength: begin
        crc_d = crc_upd;
        if (pos_q == '0) begin
          len_hi_d = byte_q[1:0];
          pos_d    = 10'd1;
        end else begin
          pos_d = '0;
          if (hdr_len == '0 || hdr_len > max_payload_q) begin
            lerr_d  = 1'b1;
            phase_d = PhHunt;
          end else begin
            frame_len_d = hdr_len;
            id_d        = '0;
            phase_d     = PhPayload;
          end
        end
      end
      PhPayload: begin
        crc_d = crc_upd;
        if (pos_q == 10'd0) begin
          id_d = {byte_q, 4'h0};
        end else if (pos_q == 10'd1) begin
          id_d = {id_q[11:4], byte_q[7:4]};
        end
        pos_d = pos_inc[9:0];
        if (pos_inc >= {1'b0, frame_len_q}) begin
          pos_d    = '0;
          crc_rx_d = '0;
          phase_d  = PhCrc;
        end
      end
      PhCrc: begin
        crc_rx_d = {crc_rx_q[15:0], byte_q};
        pos_d    = pos_inc[9:0];
        if (pos_inc >= rtcm3fp_pkg::CrcBytes) begin
          done_d  = 1'b1;
          ok_d    = (crc_q == crc_rx_d);
          mid_d   = (frame_len_q >= 10'd2) ? id_q : 12'h000;
          plen_d  = frame_len_q;
          pos_d   = '0;
          phase_d = PhHunt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      pos_q       <= '0;
      len_hi_q    <= '0;
      frame_len_q <= '0;
      crc_q       <= '0;
      crc_rx_q    <= '0;
      id_q        <= '0;
    end else if (advance) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      len_hi_q    <= len_hi_d;
      frame_len_q <= frame_len_d;
      crc_q       <= crc_d;
      crc_rx_q    <= crc_rx_d;
      id_q        <= id_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  logic        frame_done_q, crc_ok_q, length_error_q;
  logic [11:0] message_id_q;
  logic [9:0]  payload_length_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      frame_done_q     <= done_d;
      crc_ok_q         <= ok_d;
      message_id_q     <= mid_d;
      payload_length_q <= plen_d;
      length_error_q   <= lerr_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_done_o     = frame_done_q;
  assign crc_ok_o         = crc_ok_q;
  assign message_id_o     = message_id_q;
  assign payload_length_o = payload_length_q;
  assign length_error_o   = length_error_q;

`ifndef NO_ASSERTIONS
  // A result is either a frame end or a header reject, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(frame_done_q && length_error_q))
    else $error("frame_done and length_error together");

  // Frame fields stay zero unless a frame completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !frame_done_q) |->
      (!crc_ok_q && message_id_q == '0 && payload_length_q == '0))
    else $error("frame fields set without frame_done");

  // Payload counting never reaches the frame length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPayload) |-> (frame_len_q != '0 && pos_q < frame_len_q))
    else $error("payload position out of range");

  // CRC byte count stays below three
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhCrc) |-> (pos_q < 10'd3))
    else $error("CRC byte position out of range");

  // Framing state only moves when a byte is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(phase_q) && $stable(crc_q))
    else $error("state changed without a byte");
`endif

endmodule
